// File: design/csla_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csla_pkg: shared constants for the lux / color temperature unit
// Register indexes and field widths used across the design.
// ---------------------------------------------------------------------------
package csla_pkg;
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_ATIME = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAIN  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_AUTO  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_GLASS = 2'd3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned DivW = 64;
endpackage

// File: design/color_sensor_lux_cct_autogain_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// color_sensor_lux_cct_autogain_unit
// Color shares, lux, color temperature and automatic gain from one reading.
// ---------------------------------------------------------------------------
// One reading runs up to seven divisions one after another through a single
// restoring divider that retires one quotient bit per cycle; the steps load
// their operands, form a product and set up the divider in turn. Auto mode
// off saves the last division; a zero clear count, a saturated channel, lux
// over the limit or an unusable blue/red ratio skip divisions. The product
// of each step comes from one shared 32x32 multiplier; the bound checks use
// separate constant multiplies. The input is not ready while a reading is in
// work; the result sits in an output register until taken. Configuration
// words are taken only while idle with no result waiting, and ahead of a
// reading offered in the same cycle.
module color_sensor_lux_cct_autogain_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [csla_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [csla_pkg::CfgDataW-1:0]   i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [15:0]                     i_raw_clear,
    input  logic [15:0]                     i_raw_red,
    input  logic [15:0]                     i_raw_green,
    input  logic [15:0]                     i_raw_blue,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [15:0]                     o_red_share,
    output logic [15:0]                     o_green_share,
    output logic [15:0]                     o_blue_share,
    output logic [15:0]                     o_clear_share,
    output logic [20:0]                     o_lux_q4,
    output logic                            o_lux_valid,
    output logic [13:0]                     o_color_temp_kelvin,
    output logic                            o_color_temp_valid,
    output logic                            o_publish_light,
    output logic [7:0]                      o_next_atime,
    output logic [1:0]                      o_next_gain,
    output logic                            o_settings_changed
);
    import csla_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_MUL, S_DIV, S_POST, S_OUT
    } t_state;

    // job ids walk through the divisions and products
    localparam logic [3:0] J_RS = 4'd0, J_GS = 4'd1, J_BS = 4'd2, J_CS = 4'd3,
                           J_LN1 = 4'd4, J_LN2 = 4'd5, J_LD = 4'd6, J_LUX = 4'd7,
                           J_CT = 4'd8, J_AN = 4'd9, J_AUTO = 4'd10;

    t_state r_state;
    logic [3:0] r_job;
    logic [15:0] r_c, r_r, r_g, r_b;
    logic [7:0] r_atime;
    logic [1:0] r_gain;
    logic [12:0] r_tenths;
    logic r_auto;
    logic [15:0] r_glass;
    // divider
    logic [DivW-1:0] r_num, r_den, r_quo;
    logic [DivW:0] r_rem;
    logic [6:0] r_cnt;
    // shared multiplier operands and product
    logic [31:0] r_ma, r_mb;
    logic [63:0] r_prod, r_lnum, r_lden;
    logic r_sat, r_luxok;
    logic [1:0] r_ngain;
    logic [15:0] r_rs, r_gs, r_bs, r_cs;
    logic [20:0] r_lux;
    logic r_lv, r_cv, r_pub, r_chg;
    logic [13:0] r_ct;
    logic r_ovalid;

    logic [DivW:0] w_trial;
    logic [DivW:0] w_sh;
    logic [8:0] w_k;
    logic [19:0] w_sat4, w_sat4a;
    logic [63:0] w_q;
    logic [12:0] w_next;
    logic [12:0] w_rnd;
    logic [24:0] w_rcp;
    logic [7:0] w_reg;
    logic [6:0] w_gm;

    assign o_ready = (r_state == S_IDLE) && !r_ovalid && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;

    // one restoring step of the divider
    assign w_sh = {r_rem[DivW-1:0], r_num[DivW-1]};
    assign w_trial = w_sh - {1'b0, r_den};
    assign w_q = r_quo;

    // saturation threshold, scaled by four
    assign w_k = 9'd256 - {1'b0, r_atime};
    assign w_sat4a = (w_k > 9'd63) ? 20'd262140 : {w_k[7:0], 12'd0};
    assign w_sat4 = (r_tenths < 13'd1500) ? ((w_sat4a >> 2) * 20'd3) : w_sat4a;
    always_comb begin
        unique case (r_gain)
            2'd0: w_gm = 7'd1;
            2'd1: w_gm = 7'd4;
            2'd2: w_gm = 7'd16;
            default: w_gm = 7'd60;
        endcase
    end

    // auto step result selection from the clamped ideal
    // ceil(next / 24) by reciprocal multiply, exact for next up to 6144
    always_comb begin
        if (r_lnum > 64'd6144 * r_lden[31:0]) w_next = 13'd6144;
        else if (r_lnum < 64'd1540 * r_lden[31:0]) w_next = 13'd1540;
        else w_next = w_q[12:0];
        w_rnd = w_next + 13'd23;
        w_rcp = 25'(w_rnd) * 25'd2731;
        w_reg = 8'(9'd256 - w_rcp[24:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_atime <= 8'd192;
            r_gain <= 2'd0;
            r_tenths <= 13'd1536;
            r_auto <= 1'b0;
            r_glass <= 16'd256;
            r_job <= J_RS;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            // configuration words
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ATIME: begin
                        r_atime <= i_cfg_data[7:0];
                        r_tenths <= 13'((9'd256 - {1'b0, i_cfg_data[7:0]}) * 13'd24);
                    end
                    CFG_GAIN: r_gain <= i_cfg_data[1:0];
                    CFG_AUTO: r_auto <= i_cfg_data[0];
                    default:  r_glass <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_c <= i_raw_clear; r_r <= i_raw_red;
                    r_g <= i_raw_green; r_b <= i_raw_blue;
                    r_rs <= '0; r_gs <= '0; r_bs <= '0; r_cs <= '0;
                    r_lux <= '0; r_lv <= 1'b0; r_ct <= '0; r_cv <= 1'b0;
                    r_chg <= 1'b0;
                    r_pub <= !r_auto || i_raw_clear < 16'd65530 ||
                             (r_gain == 2'd0 && r_tenths < 13'd2000);
                    r_job <= (i_raw_clear == 16'd0) ? J_AN : J_RS;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    // load operands of the next job
                    r_sat <= ({2'b0, r_c} << 2) >= w_sat4 || ({2'b0, r_r} << 2) >= w_sat4
                          || ({2'b0, r_g} << 2) >= w_sat4 || ({2'b0, r_b} << 2) >= w_sat4;
                    r_state <= S_MUL;
                    unique case (r_job)
                        J_RS: begin r_ma <= {16'd0, r_r}; r_mb <= 32'd25600; end
                        J_GS: begin r_ma <= {16'd0, r_g}; r_mb <= 32'd25600; end
                        J_BS: begin r_ma <= {16'd0, r_b}; r_mb <= 32'd25600; end
                        J_CS: begin r_ma <= {16'd0, r_c}; r_mb <= 32'd600; end
                        J_LN1: begin r_ma <= {16'd0, r_glass}; r_mb <= 32'd10602; end
                        J_LN2: begin
                            r_ma <= r_prod[31:0];
                            r_mb <= 32'd580 * {16'd0, r_r} + 32'd1444 * {16'd0, r_g};
                        end
                        J_LD: begin
                            r_ma <= 32'd160000 * {19'd0, (r_tenths == 13'd0) ? 13'd1 : r_tenths};
                            r_mb <= {25'd0, w_gm};
                        end
                        J_CT: begin r_ma <= {16'd0, r_b}; r_mb <= 32'd3810; end
                        default: begin
                            r_ma <= {19'd0, r_tenths};
                            r_mb <= 32'd39321;
                        end
                    endcase
                end
                S_MUL: begin
                    r_prod <= r_ma * r_mb;
                    r_state <= S_POST;
                end
                S_POST: begin
                    r_state <= S_DIV;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= 7'd0;
                    r_num <= r_prod;
                    unique case (r_job)
                        J_RS, J_GS, J_BS: r_den <= {48'd0, r_c};
                        J_CS: r_den <= {51'd0, (r_tenths == 13'd0) ? 13'd1 : r_tenths};
                        J_LN1: begin r_state <= S_PREP; r_job <= J_LN2; end
                        J_LN2: begin
                            r_lnum <= r_prod; r_state <= S_PREP; r_job <= J_LD;
                        end
                        J_LD: begin
                            r_lden <= r_prod;
                            r_num <= r_lnum;
                            r_den <= r_prod;
                            r_luxok <= r_lnum <= r_prod * 64'd1600000;
                            r_job <= J_LUX;
                        end
                        J_CT: begin
                            r_den <= {48'd0, r_r};
                            if (r_r == 16'd0 || r_prod > 64'd13609 * r_r) begin
                                r_job <= J_AN; r_state <= S_PREP;
                            end
                        end
                        default: begin
                            r_ngain <= r_gain;
                            r_lnum <= r_prod;
                            r_lden <= {48'd0, (r_c == 16'd0) ? 16'd1 : r_c};
                            if (r_gain < 2'd3 && r_c < 16'd13107 && r_tenths > 13'd6000) begin
                                r_ngain <= r_gain + 2'd1;
                                r_lden <= {46'd0, (r_c == 16'd0) ? 16'd1 : r_c, 2'b0};
                            end
                            if (r_gain > 2'd0 && r_c > 16'd45874 && r_tenths < 13'd2000) begin
                                r_ngain <= r_gain - 2'd1;
                                r_lnum <= r_prod << 2;
                            end
                            r_job <= J_AUTO;
                            if (!r_auto) r_state <= S_OUT;
                            else r_state <= S_POST;
                        end
                    endcase
                    if (r_job == J_AUTO) begin
                        r_num <= r_lnum;
                        r_den <= r_lden;
                        r_state <= S_DIV;
                    end
                    if (r_job == J_LUX) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 7'(DivW)) begin
                        r_state <= S_PREP;
                        unique case (r_job)
                            J_RS: begin r_rs <= (|w_q[63:16]) ? 16'hFFFF : w_q[15:0]; r_job <= J_GS; end
                            J_GS: begin r_gs <= (|w_q[63:16]) ? 16'hFFFF : w_q[15:0]; r_job <= J_BS; end
                            J_BS: begin r_bs <= (|w_q[63:16]) ? 16'hFFFF : w_q[15:0]; r_job <= J_CS; end
                            J_CS: begin
                                r_cs <= (|w_q[63:16]) ? 16'hFFFF : w_q[15:0];
                                r_job <= r_sat ? J_AN : J_LN1;
                            end
                            J_LUX: begin
                                if (r_luxok) begin
                                    r_lux <= w_q[20:0]; r_lv <= 1'b1; r_job <= J_CT;
                                end else r_job <= J_AN;
                            end
                            J_CT: begin
                                r_ct <= 14'(w_q[13:0] + 14'd1391); r_cv <= 1'b1; r_job <= J_AN;
                            end
                            default: begin
                                r_state <= S_OUT;
                                if (w_reg != r_atime || r_ngain != r_gain) begin
                                    r_atime <= w_reg; r_gain <= r_ngain;
                                    r_tenths <= w_next; r_chg <= 1'b1;
                                end
                            end
                        endcase
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                        r_num <= r_num << 1;
                        if (!w_trial[DivW]) begin
                            r_rem <= w_trial; r_quo <= {r_quo[DivW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_sh; r_quo <= {r_quo[DivW-2:0], 1'b0};
                        end
                    end
                end
                default: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_red_share = r_rs;
    assign o_green_share = r_gs;
    assign o_blue_share = r_bs;
    assign o_clear_share = r_cs;
    assign o_lux_q4 = r_lux;
    assign o_lux_valid = r_lv;
    assign o_color_temp_kelvin = r_ct;
    assign o_color_temp_valid = r_cv;
    assign o_publish_light = r_pub;
    assign o_next_atime = r_atime;
    assign o_next_gain = r_gain;
    assign o_settings_changed = r_chg;

    // temperature is only reported together with lux
    a_ct_lux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_color_temp_valid |-> o_lux_valid) else $error("ct without lux");
    // no input taken while busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready) else $error("ready while busy");
    // changed flag only in auto mode
    a_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_settings_changed |-> r_auto) else $error("change without auto");
endmodule

// File: sim/tb_color_sensor_lux_cct_autogain_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_color_sensor_lux_cct_autogain_unit
// Drives raw clear/red/green/blue words into the lux / color temperature
// unit and checks every result word field by field against an exact
// integer model or a fixed word. A short directed table comes first. Random
// phases follow, each with its own register settings and handshake idling.
// ---------------------------------------------------------------------------
module tb_color_sensor_lux_cct_autogain_unit;
    import csla_pkg::*;

    typedef struct packed {
        logic [15:0] clear;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_reading;

    typedef struct packed {
        logic [15:0] red_share;
        logic [15:0] green_share;
        logic [15:0] blue_share;
        logic [15:0] clear_share;
        logic [20:0] lux_q4;
        logic        lux_valid;
        logic [13:0] color_temp_kelvin;
        logic        color_temp_valid;
        logic        publish_light;
        logic [7:0]  next_atime;
        logic [1:0]  next_gain;
        logic        settings_changed;
    } t_light_res;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_FIXED} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  cfg_idx;
        logic [15:0] cfg_data;
        t_reading    rd;
        t_light_res  fixed;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_raw_clear = '0;
    logic [15:0] i_raw_red = '0;
    logic [15:0] i_raw_green = '0;
    logic [15:0] i_raw_blue = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_red_share;
    logic [15:0] o_green_share;
    logic [15:0] o_blue_share;
    logic [15:0] o_clear_share;
    logic [20:0] o_lux_q4;
    logic        o_lux_valid;
    logic [13:0] o_color_temp_kelvin;
    logic        o_color_temp_valid;
    logic        o_publish_light;
    logic [7:0]  o_next_atime;
    logic [1:0]  o_next_gain;
    logic        o_settings_changed;

    color_sensor_lux_cct_autogain_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    // model copy of registers and state
    longint unsigned m_auto;
    longint unsigned m_glass;
    longint unsigned m_atime;
    longint unsigned m_gain;
    longint unsigned m_tenths;

    t_light_res expected_lights[$];
    t_stim_row  stim_table[$];
    int         fail_count = 0;
    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;

    function automatic longint unsigned sat16(longint unsigned v);
        return (v > 65535) ? 65535 : v;
    endfunction

    // exact integer model of one step, advances model state
    task automatic predict_light(input t_reading rd, output t_light_res res);
        longint unsigned c, r, g, b, t, gc, k, sat4, num, den, gmul;
        longint unsigned new_gain, next, reg_v, cm;
        logic saturated;
        c = 64'(rd.clear); r = 64'(rd.red); g = 64'(rd.green); b = 64'(rd.blue);
        t = (m_tenths != 0) ? m_tenths : 1;
        gc = m_gain;
        res = '0;
        if (c != 0) begin
            k = 256 - m_atime;
            sat4 = (k > 63) ? 262140 : 4096 * k;
            res.red_share   = 16'(sat16(r * 25600 / c));
            res.green_share = 16'(sat16(g * 25600 / c));
            res.blue_share  = 16'(sat16(b * 25600 / c));
            res.clear_share = 16'(sat16(c * 600 / t));
            if (m_tenths < 1500) sat4 = sat4 / 4 * 3;
            saturated = (c * 4 >= sat4) || (r * 4 >= sat4) ||
                        (g * 4 >= sat4) || (b * 4 >= sat4);
            if (!saturated) begin
                case (gc)
                    0: gmul = 1;
                    1: gmul = 4;
                    2: gmul = 16;
                    default: gmul = 60;
                endcase
                num = 10602 * (580 * r + 1444 * g) * m_glass;
                den = 160000 * t * gmul;
                if (num <= 1600000 * den) begin
                    res.lux_q4 = 21'(num / den);
                    res.lux_valid = 1'b1;
                    if (r != 0 && 3810 * b <= 13609 * r) begin
                        res.color_temp_kelvin = 14'(3810 * b / r + 1391);
                        res.color_temp_valid = 1'b1;
                    end
                end
            end
        end
        res.publish_light = (m_auto == 0 || c < 65530 ||
                             (gc == 0 && m_tenths < 2000));
        // automatic gain and integration step
        if (m_auto != 0) begin
            cm = (c != 0) ? c : 1;
            num = 39321 * m_tenths;
            den = cm;
            new_gain = gc;
            if (gc < 3 && c < 13107 && m_tenths > 6000) begin
                new_gain = gc + 1;
                den = den * 4;
            end
            if (gc > 0 && c > 45874 && m_tenths < 2000) begin
                new_gain = gc - 1;
                num = num * 4;
            end
            if (num > 6144 * den) next = 6144;
            else if (num < 1540 * den) next = 1540;
            else next = num / den;
            reg_v = 256 - (next + 23) / 24;
            if (reg_v != m_atime || new_gain != gc) begin
                m_atime = reg_v & 8'hFF;
                m_gain = new_gain & 2'h3;
                m_tenths = next;
                res.settings_changed = 1'b1;
            end
        end
        res.next_atime = 8'(m_atime);
        res.next_gain = 2'(m_gain);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ATIME: begin
                m_atime = 64'(data[7:0]);
                m_tenths = (256 - m_atime) * 24;
            end
            CFG_GAIN: m_gain = 64'(data[1:0]);
            CFG_AUTO: m_auto = 64'(data[0]);
            CFG_GLASS: m_glass = 64'(data);
        endcase
    endtask

    // hold off until every result has come back, then let the block settle
    task automatic drain_results();
        while (expected_lights.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_reading(input t_reading rd, input bit use_fixed,
                                input t_light_res fixed);
        int gap;
        t_light_res res;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < snd_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_clear <= rd.clear;
        i_raw_red <= rd.red;
        i_raw_green <= rd.green;
        i_raw_blue <= rd.blue;
        do @(posedge i_clk); while (!o_ready);
        predict_light(rd, res);
        expected_lights.push_back(use_fixed ? fixed : res);
    endtask

    function automatic t_reading rand_reading();
        t_reading rd;
        int mode;
        logic [15:0] picks [5] = '{16'd0, 16'd1, 16'd65535, 16'd65534, 16'd65530};
        mode = $urandom_range(0, 9);
        if (mode <= 5) begin
            // plausible scene: channels a fraction of clear
            rd.clear = 16'($urandom_range(1, 65535) >> $urandom_range(0, 14));
            rd.red   = 16'(rd.clear * $urandom_range(0, 100) / 100);
            rd.green = 16'(rd.clear * $urandom_range(0, 100) / 100);
            rd.blue  = 16'(rd.clear * $urandom_range(0, 100) / 100);
        end else if (mode == 6) begin
            rd = {$urandom, $urandom};
        end else if (mode == 7) begin
            rd.clear = picks[$urandom_range(0, 4)];
            rd.red   = picks[$urandom_range(0, 4)];
            rd.green = picks[$urandom_range(0, 4)];
            rd.blue  = picks[$urandom_range(0, 4)];
        end else if (mode == 8) begin
            // around the saturation threshold
            rd.clear = 16'((m_tenths * 128 / 3) + $urandom_range(0, 64) - 32);
            rd.red   = rd.clear >> $urandom_range(0, 3);
            rd.green = rd.clear >> $urandom_range(0, 3);
            rd.blue  = rd.clear >> $urandom_range(0, 3);
        end else begin
            rd.clear = 16'($urandom_range(0, 3));
            rd.red   = 16'($urandom_range(0, 3));
            rd.green = 16'($urandom_range(0, 3));
            rd.blue  = 16'($urandom_range(0, 3));
        end
        return rd;
    endfunction

    task automatic add_cfg(input logic [1:0] idx, input logic [15:0] data);
        t_stim_row row;
        row = '{ROW_CFG, idx, data, '0, '0};
        stim_table.push_back(row);
    endtask

    task automatic add_item(input logic [15:0] c, r, g, b);
        t_stim_row row;
        row = '{ROW_ITEM, '0, '0, {c, r, g, b}, '0};
        stim_table.push_back(row);
    endtask

    task automatic add_fixed(input logic [15:0] c, r, g, b, input t_light_res exp_res);
        t_stim_row row;
        row = '{ROW_FIXED, '0, '0, {c, r, g, b}, exp_res};
        stim_table.push_back(row);
    endtask

    // receiver: random stall
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result word check against the oldest expectation
    always @(posedge i_clk) begin
        t_light_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_lights.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                e = expected_lights.pop_front();
                check_field("red_share", e.red_share, o_red_share);
                check_field("green_share", e.green_share, o_green_share);
                check_field("blue_share", e.blue_share, o_blue_share);
                check_field("clear_share", e.clear_share, o_clear_share);
                check_field("lux_q4", e.lux_q4, o_lux_q4);
                check_field("lux_valid", e.lux_valid, o_lux_valid);
                check_field("color_temp_kelvin", e.color_temp_kelvin,
                            o_color_temp_kelvin);
                check_field("color_temp_valid", e.color_temp_valid, o_color_temp_valid);
                check_field("publish_light", e.publish_light, o_publish_light);
                check_field("next_atime", e.next_atime, o_next_atime);
                check_field("next_gain", e.next_gain, o_next_gain);
                check_field("settings_changed", e.settings_changed, o_settings_changed);
            end
        end
    end

    initial begin
        #40ms;
        $display("tb_color_sensor_lux_cct_autogain_unit NOT OK");
        $finish;
    end

    initial begin
        t_stim_row row;
        t_reading rd;
        int phase;
        int n;
        m_auto = 0; m_glass = 256; m_atime = 192; m_gain = 0; m_tenths = 1536;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed table, reset settings first
        add_fixed(16'd0, 16'd0, 16'd0, 16'd0,
                  '{16'd0, 16'd0, 16'd0, 16'd0, 21'd0, 1'b0, 14'd0, 1'b0,
                    1'b1, 8'd192, 2'd0, 1'b0});
        add_fixed(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  '{16'd25600, 16'd25600, 16'd25600, 16'd25599, 21'd0, 1'b0,
                    14'd0, 1'b0, 1'b1, 8'd192, 2'd0, 1'b0});
        add_item(16'd1, 16'hFFFF, 16'd0, 16'd0);
        add_item(16'd1000, 16'd0, 16'd500, 16'd300);
        add_item(16'd20000, 16'd6000, 16'd8000, 16'd5000);
        add_item(16'd30000, 16'd10, 16'd100, 16'd29000);
        add_cfg(CFG_GLASS, 16'd0);
        add_item(16'd20000, 16'd6000, 16'd8000, 16'd5000);
        // shortest integration, heaviest glass: lux over the limit
        add_cfg(CFG_ATIME, 16'd255);
        add_cfg(CFG_GLASS, 16'hFFFF);
        add_item(16'd700, 16'd100, 16'd700, 16'd50);
        add_item(16'd767, 16'd767, 16'd767, 16'd767);
        add_item(16'd768, 16'd10, 16'd10, 16'd10);
        // longest integration in auto mode: gain up on dim readings, shorter integration on a bright one
        add_cfg(CFG_GLASS, 16'd1);
        add_cfg(CFG_ATIME, 16'd0);
        add_cfg(CFG_AUTO, 16'd1);
        add_item(16'd100, 16'd30, 16'd40, 16'd20);
        add_item(16'd40000, 16'd12000, 16'd15000, 16'd9000);
        add_item(16'd0, 16'd0, 16'd0, 16'd0);
        // saturated clear with gain above 1x: publish withheld
        add_cfg(CFG_ATIME, 16'd0);
        add_cfg(CFG_GAIN, 16'd1);
        add_item(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        // short integration at top gain: gain down
        add_cfg(CFG_ATIME, 16'd200);
        add_cfg(CFG_GAIN, 16'd3);
        add_item(16'd50000, 16'd20000, 16'd20000, 16'd9000);
        add_item(16'd65535, 16'd30000, 16'd30000, 16'd30000);

        snd_idle_pct = 24;
        rcv_idle_pct = 86;
        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.kind == ROW_CFG) begin
                i_valid <= 1'b0;
                drain_results();
                cfg_write(row.cfg_idx, row.cfg_data);
            end else begin
                send_reading(row.rd, row.kind == ROW_FIXED, row.fixed);
            end
        end

        // random phases, each with fresh settings
        for (phase = 0; phase < 12; phase++) begin
            if (phase < 4) begin
                snd_idle_pct = 24; rcv_idle_pct = 86;
            end else if (phase < 8) begin
                snd_idle_pct = 86; rcv_idle_pct = 24;
            end else begin
                snd_idle_pct = 0; rcv_idle_pct = 0;
            end
            i_valid <= 1'b0;
            drain_results();
            case ($urandom_range(0, 2))
                0: cfg_write(CFG_ATIME, 16'd0);
                1: cfg_write(CFG_ATIME, 16'd255);
                default: cfg_write(CFG_ATIME, 16'($urandom_range(0, 255)));
            endcase
            cfg_write(CFG_GAIN, 16'($urandom_range(0, 3)));
            cfg_write(CFG_AUTO, {15'd0, ($urandom_range(0, 2) != 0)});
            case ($urandom_range(0, 3))
                0: cfg_write(CFG_GLASS, 16'd1);
                1: cfg_write(CFG_GLASS, 16'hFFFF);
                2: cfg_write(CFG_GLASS, 16'd256);
                default: cfg_write(CFG_GLASS, 16'($urandom_range(1, 65535)));
            endcase
            for (n = 0; n < 119; n++) begin
                rd = rand_reading();
                send_reading(rd, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (expected_lights.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_color_sensor_lux_cct_autogain_unit OK");
        end else begin
            $display("tb_color_sensor_lux_cct_autogain_unit NOT OK");
        end
        $finish;
    end
endmodule

// File: color_sensor_lux_cct_autogain_unit.f
design/csla_pkg.sv
design/color_sensor_lux_cct_autogain_unit.sv
sim/tb_color_sensor_lux_cct_autogain_unit.sv
